@@ src/assert_macros.svh @@
// Assertion helpers: clocked check and a never-true check, both reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ src/spc_pkg.sv @@
`default_nettype none
package spc_pkg;

  localparam int US_W      = 16;
  localparam int TS_W      = 32;
  localparam int POS_W     = 23;
  localparam int FRQ_W     = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [US_W-1:0]      SAT_US            = 16'hFFFF;
  localparam logic [POS_W-1:0]     PERCENT_SCALE     = 23'd100;
  localparam logic [FRQ_W-1:0]     MICROS_PER_SECOND = 20'd1000000;
  localparam logic [US_W-1:0]      MIN_WIDTH_RESET   = 16'd1000;
  localparam logic [US_W-1:0]      MAX_WIDTH_RESET   = 16'd2000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX       = 1'b1;

  // One restoring step per quotient bit, sized for the wider numerator.
  localparam int DIV_STEPS = POS_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [US_W-1:0] width;
    logic [US_W-1:0] period;
  } spc_item_t;

endpackage
`default_nettype wire

@@ src/spc_front.sv @@
`default_nettype none
module spc_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [31:0]               timestamp_us,
  input  wire                       pin_level,
  output logic                      push_valid,
  input  wire                       push_ready,
  output spc_pkg::spc_item_t        push_item
);
  import spc_pkg::*;

  logic            previous_level;
  logic [TS_W-1:0] last_rise_time;
  logic [US_W-1:0] held_width;
  logic [US_W-1:0] held_period;

  logic            accept;
  logic            rise;
  logic            fall;
  logic [TS_W-1:0] delta;
  logic [US_W-1:0] delta_sat;
  logic [US_W-1:0] held_width_next;
  logic [US_W-1:0] held_period_next;

  assign in_stall   = !push_ready;
  assign accept     = in_valid && push_ready;
  assign push_valid = in_valid;

  assign rise      = !previous_level && pin_level;
  assign fall      = previous_level && !pin_level;
  assign delta     = timestamp_us - last_rise_time;
  assign delta_sat = (|delta[TS_W-1:US_W]) ? SAT_US : delta[US_W-1:0];

  assign held_width_next  = fall ? delta_sat : held_width;
  assign held_period_next = rise ? delta_sat : held_period;

  assign push_item.width  = held_width_next;
  assign push_item.period = held_period_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      last_rise_time <= '0;
      held_width     <= '0;
      held_period    <= '0;
    end else if (accept) begin
      previous_level <= pin_level;
      held_width     <= held_width_next;
      held_period    <= held_period_next;
      if (rise) begin
        last_rise_time <= timestamp_us;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/spc_queue.sv @@
`default_nettype none
module spc_queue #(
  parameter int DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push_valid,
  output logic                push_ready,
  input  spc_pkg::spc_item_t  push_item,
  output logic                pop_valid,
  input  wire                 pop_ready,
  output spc_pkg::spc_item_t  pop_item
);
  import spc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  spc_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/spc_back.sv @@
`default_nettype none
module spc_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [15:0]         min_width,
  input  wire  [15:0]         max_width,
  input  wire                 pop_valid,
  output logic                pop_ready,
  input  spc_pkg::spc_item_t  pop_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [15:0]         pulse_width_us,
  output logic [15:0]         period_us,
  output logic [22:0]         position_percent,
  output logic [19:0]         frequency_hz
);
  import spc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step_cnt;
  logic [US_W-1:0]   cur_width;
  logic [US_W-1:0]   cur_period;
  logic              pos_zero;
  logic              frq_zero;
  logic [POS_W-1:0]  num_pos;
  logic [US_W-1:0]   den_pos;
  logic [US_W-1:0]   rem_pos;
  logic [POS_W-1:0]  num_frq;
  logic [US_W-1:0]   den_frq;
  logic [US_W-1:0]   rem_frq;

  logic              take;
  logic              load_out;
  logic              pos_ok;
  logic [US_W-1:0]   span;
  logic [US_W-1:0]   excess;
  logic [US_W:0]     t_pos;
  logic [US_W:0]     t_frq;
  logic              ge_pos;
  logic              ge_frq;

  assign pop_ready = (state == ST_IDLE);
  assign take      = pop_valid && pop_ready;
  assign load_out  = (state == ST_DONE) && (!out_valid || !out_stall);

  assign pos_ok = (pop_item.width >= min_width) && (max_width > min_width);
  assign span   = max_width - min_width;
  assign excess = pop_item.width - min_width;

  // One restoring step on each divider per cycle while in ST_DIV.
  assign t_pos  = {rem_pos, num_pos[POS_W-1]};
  assign t_frq  = {rem_frq, num_frq[POS_W-1]};
  assign ge_pos = t_pos >= {1'b0, den_pos};
  assign ge_frq = t_frq >= {1'b0, den_frq};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            state    <= ST_DIV;
            step_cnt <= '0;
          end
        end
        ST_DIV: begin
          if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
          step_cnt <= step_cnt + 1'b1;
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_width  <= pop_item.width;
      cur_period <= pop_item.period;
      pos_zero   <= !pos_ok;
      frq_zero   <= (pop_item.period == '0);
      num_pos    <= pos_ok ? POS_W'(excess) * PERCENT_SCALE : '0;
      den_pos    <= pos_ok ? span : US_W'(1);
      rem_pos    <= '0;
      num_frq    <= POS_W'(MICROS_PER_SECOND);
      den_frq    <= pop_item.period;
      rem_frq    <= '0;
    end else if (state == ST_DIV) begin
      num_pos <= {num_pos[POS_W-2:0], ge_pos};
      rem_pos <= ge_pos ? US_W'(t_pos - {1'b0, den_pos}) : t_pos[US_W-1:0];
      num_frq <= {num_frq[POS_W-2:0], ge_frq};
      rem_frq <= ge_frq ? US_W'(t_frq - {1'b0, den_frq}) : t_frq[US_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pulse_width_us   <= cur_width;
      period_us        <= cur_period;
      position_percent <= pos_zero ? '0 : num_pos;
      frequency_hz     <= frq_zero ? '0 : num_frq[FRQ_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ src/servo_pwm_capture_top.sv @@
// Servo PWM capture: pulse width, period, position and frequency.
// Input channel: in_valid / in_stall with timestamp_us (microseconds) and
// pin_level. A transfer takes place on a clock edge with valid high and
// stall low. A rising pin edge stores the rise-to-rise period, a falling
// edge stores the high width, both saturated at 65535 us.
// Output channel: out_valid / out_stall; every input transfer yields one
// result with the held width, period, position in percent and frequency.
// A 23-step restoring divider pair in the back end works out position
// and frequency together; it takes no new item until the previous
// result has been loaded into the output register.
// A queue of QUEUE_DEPTH items sits between edge capture and the divider,
// so the front accepts samples while a result waits at the output.
// When the receiver stalls, the output register holds its result, the
// divider finishes the next item and waits, then the queue fills and
// in_stall rises. Reset (rst, synchronous) clears the pin history, rise
// time and held values and loads min/max widths of 1000 and 2000 us.
// Write cfg_index 0 (min width) or 1 (max width) with cfg_write while idle.
`default_nettype none
`include "assert_macros.svh"
module servo_pwm_capture_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] timestamp_us,
  input  wire         pin_level,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [15:0] pulse_width_us,
  output logic [15:0] period_us,
  output logic [22:0] position_percent,
  output logic [19:0] frequency_hz,
  input  wire         cfg_write,
  input  wire  [0:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import spc_pkg::*;

  logic [US_W-1:0] percent_min_width;
  logic [US_W-1:0] percent_max_width;

  logic      push_valid;
  logic      push_ready;
  spc_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  spc_item_t pop_item;
  logic      pos_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_min_width <= MIN_WIDTH_RESET;
      percent_max_width <= MAX_WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IDX_MIN: percent_min_width <= cfg_data;
        CFG_IDX_MAX: percent_max_width <= cfg_data;
        default: begin
          percent_min_width <= percent_min_width;
        end
      endcase
    end
  end

  spc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .timestamp_us (timestamp_us),
    .pin_level    (pin_level),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  spc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  spc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .min_width        (percent_min_width),
    .max_width        (percent_max_width),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pulse_width_us   (pulse_width_us),
    .period_us        (period_us),
    .position_percent (position_percent),
    .frequency_hz     (frequency_hz)
  );

  assign pos_set = out_valid && (position_percent != '0);

  `ASSERT_NEVER(a_pos_below_min, clk, rst, pos_set && (pulse_width_us < percent_min_width))
  `ASSERT_NEVER(a_pos_bad_span, clk, rst, pos_set && (percent_max_width <= percent_min_width))
  `ASSERT_CLK(a_frq_zero_period, clk, rst, out_valid && (period_us == '0) |-> frequency_hz == '0)

endmodule
`default_nettype wire
